// ===== rtl/i2cmls_pkg.sv =====
// Shared types and constants for the I2C master line sequencer.
`default_nettype none

package i2cmls_pkg;

  // Request mode codes as they arrive on the input channel
  typedef enum logic [2:0] {
    MODE_START    = 3'd0,
    MODE_STOP     = 3'd1,
    MODE_WRITE    = 3'd2,
    MODE_READ     = 3'd3,
    MODE_SEND_ACK = 3'd4,
    MODE_RECV_ACK = 3'd5
  } mode_t;

  // Line-write programs run by the back end
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_SHIFT = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // What the final line write reports
  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_BYTE = 2'd1,
    RES_ACK  = 2'd2
  } res_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;      // SDA levels, MSB first
    logic [2:0] last_bit;  // index of the final bit slot
    res_t       res;
    logic [7:0] sample;    // sampled line levels
  } cmd_t;

  localparam int         QUEUE_DEPTH   = 2;
  localparam logic [7:0] MSB_MASK      = 8'h80;
  localparam logic [2:0] BYTE_LAST_BIT = 3'd7;
  localparam logic [2:0] ONE_LAST_BIT  = 3'd0;

  // Phase codes inside one bit slot
  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_FOUR = 2'd3;

endpackage : i2cmls_pkg

`default_nettype wire

// ===== rtl/i2cmls_front.sv =====
// Front end: accept requests and classify them into line-write programs.
`default_nettype none

module i2cmls_front
  import i2cmls_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_mode,
  input  wire logic [7:0] in_tx_byte,
  input  wire logic       in_ack_out,
  input  wire logic [7:0] in_line_bits,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  logic known;

  assign in_stall = q_full;

  always_comb begin
    known           = 1'b1;
    q_cmd.op        = OP_START;
    q_cmd.data      = '0;
    q_cmd.last_bit  = ONE_LAST_BIT;
    q_cmd.res       = RES_NONE;
    q_cmd.sample    = in_line_bits;
    case (in_mode)
      MODE_START: begin
        q_cmd.op = OP_START;
      end
      MODE_STOP: begin
        q_cmd.op = OP_STOP;
      end
      MODE_WRITE: begin
        q_cmd.op       = OP_SHIFT;
        q_cmd.data     = in_tx_byte;
        q_cmd.last_bit = BYTE_LAST_BIT;
      end
      MODE_READ: begin
        q_cmd.op       = OP_READ;
        q_cmd.last_bit = BYTE_LAST_BIT;
        q_cmd.res      = RES_BYTE;
      end
      MODE_SEND_ACK: begin
        q_cmd.op   = OP_SHIFT;
        q_cmd.data = in_ack_out ? MSB_MASK : '0;
      end
      MODE_RECV_ACK: begin
        q_cmd.op   = OP_SHIFT;
        q_cmd.data = MSB_MASK;
        q_cmd.res  = RES_ACK;
      end
      default: begin
        // drop unused codes: no line writes
        known = 1'b0;
      end
    endcase
  end

  assign q_push = in_valid && !q_full && known;

endmodule : i2cmls_front

`default_nettype wire

// ===== rtl/i2cmls_queue.sv =====
// Short request queue between the front and back ends.
`default_nettype none

module i2cmls_queue
  import i2cmls_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule : i2cmls_queue

`default_nettype wire

// ===== rtl/i2cmls_back.sv =====
// Back end: run one line-write program per request, one pin write a cycle when not stalled.
`default_nettype none

module i2cmls_back
  import i2cmls_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_empty,
  input  wire cmd_t       head,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_scl,
  output logic            out_sda,
  output logic [7:0]      out_rx_byte,
  output logic            out_ack_in,
  output logic            out_last
);

  // running program and line state
  logic       busy_r, busy_nxt;
  cmd_t       cur_r, cur_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic       scl_lvl_r, scl_lvl_nxt;
  logic       sda_lvl_r, sda_lvl_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic       out_scl_r, out_sda_r, out_ack_r, out_last_r;
  logic [7:0] out_rx_r;

  // active program view
  cmd_t       act;
  logic [1:0] act_phase;
  logic [2:0] act_bit;
  logic [7:0] act_sh;
  logic       adv, have, step, fin;
  logic [1:0] ph_inc;

  always_comb begin
    act       = busy_r ? cur_r : head;
    act_phase = busy_r ? phase_r : PH_DATA;
    act_bit   = busy_r ? bit_r : '0;
    act_sh    = busy_r ? sh_r : head.data;
    adv       = !out_valid_r || !out_stall;
    have      = busy_r || !q_empty;
    step      = adv && have;
    q_pop     = adv && !busy_r && !q_empty;
    ph_inc    = 2'(act_phase + 2'd1);

    scl_lvl_nxt = scl_lvl_r;
    sda_lvl_nxt = sda_lvl_r;
    fin         = 1'b0;
    phase_nxt   = ph_inc;
    bit_nxt     = act_bit;
    sh_nxt      = act_sh;

    case (act.op)
      OP_START: begin
        case (act_phase)
          PH_DATA: sda_lvl_nxt = 1'b1;
          PH_HIGH: scl_lvl_nxt = 1'b1;
          PH_LOW:  sda_lvl_nxt = 1'b0;
          default: scl_lvl_nxt = 1'b0;
        endcase
        fin = (act_phase == PH_FOUR);
      end
      OP_STOP: begin
        case (act_phase)
          PH_DATA: sda_lvl_nxt = 1'b0;
          PH_HIGH: scl_lvl_nxt = 1'b1;
          default: sda_lvl_nxt = 1'b1;
        endcase
        fin = (act_phase == PH_LOW);
      end
      OP_SHIFT: begin
        case (act_phase)
          PH_DATA: sda_lvl_nxt = act_sh[7];
          PH_HIGH: scl_lvl_nxt = 1'b1;
          default: begin
            scl_lvl_nxt = 1'b0;
            fin         = (act_bit == act.last_bit);
            phase_nxt   = PH_DATA;
            bit_nxt     = 3'(act_bit + 3'd1);
            sh_nxt      = {act_sh[6:0], 1'b0};
          end
        endcase
      end
      default: begin  // OP_READ: release SDA once, then clock pulses only
        case (act_phase)
          PH_DATA: sda_lvl_nxt = 1'b1;
          PH_HIGH: scl_lvl_nxt = 1'b1;
          default: begin
            scl_lvl_nxt = 1'b0;
            fin         = (act_bit == act.last_bit);
            phase_nxt   = PH_HIGH;
            bit_nxt     = 3'(act_bit + 3'd1);
          end
        endcase
      end
    endcase

    busy_nxt      = busy_r;
    cur_nxt       = q_pop ? head : cur_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = have;
    end
    if (step) begin
      busy_nxt = !fin;
      if (fin) begin
        phase_nxt = PH_DATA;
        bit_nxt   = '0;
      end
    end else begin
      phase_nxt   = phase_r;
      bit_nxt     = bit_r;
      sh_nxt      = sh_r;
      scl_lvl_nxt = scl_lvl_r;
      sda_lvl_nxt = sda_lvl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_DATA;
      bit_r       <= '0;
      scl_lvl_r   <= 1'b1;
      sda_lvl_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      bit_r       <= bit_nxt;
      scl_lvl_r   <= scl_lvl_nxt;
      sda_lvl_r   <= sda_lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    sh_r  <= sh_nxt;
    if (step) begin
      out_scl_r  <= scl_lvl_nxt;
      out_sda_r  <= sda_lvl_nxt;
      out_last_r <= fin;
      out_rx_r   <= (fin && act.res == RES_BYTE) ? act.sample : '0;
      out_ack_r  <= fin && act.res == RES_ACK && act.sample[7];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_scl     = out_scl_r;
  assign out_sda     = out_sda_r;
  assign out_rx_byte = out_rx_r;
  assign out_ack_in  = out_ack_r;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (phase_r == PH_DATA && bit_r == '0))
    else $error("idle back end holds nonzero counters");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!q_empty && !busy_r))
    else $error("pop without a queued request");

  a_mid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_rx_r == '0 && !out_ack_r))
    else $error("result data on a non-final line write");

  a_read_no_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cur_r.op == OP_READ) |-> (phase_r != PH_DATA))
    else $error("read program went back to its release phase");

  a_step_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (out_valid_r && out_scl_r == scl_lvl_r && out_sda_r == sda_lvl_r))
    else $error("output register out of step with line levels");
`endif

endmodule : i2cmls_back

`default_nettype wire

// ===== rtl/i2c_master_line_sequencer.sv =====
// A taken request is queued; its first line write then goes through the output register.
// Throughput: one line write per cycle unless out_stall holds it; a request makes its writes
// (start 4, stop 3, write 24, read 17, send or receive acknowledge 3), with no gap between.
// The back end's one-write-per-cycle sequencer sets that figure; unused mode codes take none.
// Reset (synchronous, rst_n low): queue emptied, output invalid, SCL and SDA levels released.
`default_nettype none

module i2c_master_line_sequencer
  import i2cmls_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // request channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_mode,
  input  wire logic [7:0] in_tx_byte,
  input  wire logic       in_ack_out,
  input  wire logic [7:0] in_line_bits,
  // line-write channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_scl,
  output logic            out_sda,
  output logic [7:0]      out_rx_byte,
  output logic            out_ack_in,
  output logic            out_last
);

  // Front end classifies a request into a compact program record
  cmd_t q_cmd;
  cmd_t q_head;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  i2cmls_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_tx_byte   (in_tx_byte),
    .in_ack_out   (in_ack_out),
    .in_line_bits (in_line_bits),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  // Queue lets the front keep taking requests while a long write drains
  i2cmls_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back end: start the head program in the same cycle it is popped, then
  // advance one pin write per cycle into the output register unless stalled
  i2cmls_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .head        (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_scl     (out_scl),
    .out_sda     (out_sda),
    .out_rx_byte (out_rx_byte),
    .out_ack_in  (out_ack_in),
    .out_last    (out_last)
  );

endmodule : i2c_master_line_sequencer

`default_nettype wire

// ===== dv/i2cmls_line_checker.sv =====
// Checker for the I2C line sequencer: predicts each request's line writes and compares them.
module i2cmls_line_checker
  import i2cmls_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] in_mode,
  input  logic [7:0] in_tx_byte,
  input  logic       in_ack_out,
  input  logic [7:0] in_line_bits,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_scl,
  input  logic       out_sda,
  input  logic [7:0] out_rx_byte,
  input  logic       out_ack_in,
  input  logic       out_last,
  output int         pending_writes,
  output int         mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] rx_byte;
    logic       ack_in;
    logic       last;
  } line_write_t;

  line_write_t expected_writes[$];
  line_write_t want;
  logic        scl_lvl = 1'b1;
  logic        sda_lvl = 1'b1;
  int          errors  = 0;

  // record the bus levels after one pin write
  function automatic void log_write();
    expected_writes.push_back('{scl: scl_lvl, sda: sda_lvl, rx_byte: 8'h00,
                                ack_in: 1'b0, last: 1'b0});
  endfunction

  function automatic void set_scl(input logic lvl);
    scl_lvl = lvl;
    log_write();
  endfunction

  function automatic void set_sda(input logic lvl);
    sda_lvl = lvl;
    log_write();
  endfunction

  function automatic void pulse_scl();
    set_scl(1'b1);
    set_scl(1'b0);
  endfunction

  function automatic void predict_line_writes(input logic [2:0] mode, input logic [7:0] tx,
                                              input logic ack, input logic [7:0] bits);
    line_write_t tail;
    case (mode)
      MODE_START: begin
        set_sda(1'b1);
        set_scl(1'b1);
        set_sda(1'b0);
        set_scl(1'b0);
      end
      MODE_STOP: begin
        set_sda(1'b0);
        set_scl(1'b1);
        set_sda(1'b1);
      end
      MODE_WRITE: begin
        for (int i = 7; i >= 0; i--) begin
          set_sda(tx[i]);
          pulse_scl();
        end
      end
      MODE_READ: begin
        set_sda(1'b1);
        for (int i = 0; i < 8; i++) pulse_scl();
      end
      MODE_SEND_ACK: begin
        set_sda(ack);
        pulse_scl();
      end
      MODE_RECV_ACK: begin
        set_sda(1'b1);
        pulse_scl();
      end
      default: return;  // unused codes leave the lines alone
    endcase
    tail = expected_writes[expected_writes.size() - 1];
    tail.last = 1'b1;
    if (mode == MODE_READ) tail.rx_byte = bits;
    if (mode == MODE_RECV_ACK) tail.ack_in = ((bits & MSB_MASK) != 8'h00);
    expected_writes[expected_writes.size() - 1] = tail;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_val,
                                      input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: %s expected %0h got %0h", $realtime, name, exp_val, act_val);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      scl_lvl = 1'b1;
      sda_lvl = 1'b1;
      expected_writes.delete();
    end else begin
      if (in_valid && !in_stall)
        predict_line_writes(in_mode, in_tx_byte, in_ack_out, in_line_bits);
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected line write scl=%0b sda=%0b last=%0b",
                     $realtime, out_scl, out_sda, out_last);
        end else begin
          want = expected_writes.pop_front();
          check_field("scl", 8'(want.scl), 8'(out_scl));
          check_field("sda", 8'(want.sda), 8'(out_sda));
          check_field("rx_byte", want.rx_byte, out_rx_byte);
          check_field("ack_in", 8'(want.ack_in), 8'(out_ack_in));
          check_field("last", 8'(want.last), 8'(out_last));
        end
      end
    end
    pending_writes <= expected_writes.size();
    mismatch_count <= errors;
  end

endmodule

// ===== dv/tb_i2c_master_line_sequencer.sv =====
// Top-level testbench for the I2C line sequencer: request stimulus, stall control and verdict.
module tb_i2c_master_line_sequencer;
  import i2cmls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF_NS     = 2;
  localparam int RESET_CYCLES    = 8;
  localparam int TARGET_REQUESTS = 400;
  // no acceptance on either side for this long means the block is hung
  localparam int QUIET_LIMIT     = 5000;
  // a request makes at most 24 writes; give stray writes time to show up
  localparam int SETTLE_CYCLES   = 32;
  // mode codes the block must ignore
  localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [2:0] in_mode      = MODE_START;
  logic [7:0] in_tx_byte   = 8'h00;
  logic       in_ack_out   = 1'b0;
  logic [7:0] in_line_bits = 8'h00;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic       out_scl;
  logic       out_sda;
  logic [7:0] out_rx_byte;
  logic       out_ack_in;
  logic       out_last;

  int pending_writes;
  int mismatch_count;
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int requests_sent  = 0;
  int quiet_cycles   = 0;

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  i2c_master_line_sequencer dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_tx_byte   (in_tx_byte),
    .in_ack_out   (in_ack_out),
    .in_line_bits (in_line_bits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_scl      (out_scl),
    .out_sda      (out_sda),
    .out_rx_byte  (out_rx_byte),
    .out_ack_in   (out_ack_in),
    .out_last     (out_last)
  );

  i2cmls_line_checker line_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_tx_byte     (in_tx_byte),
    .in_ack_out     (in_ack_out),
    .in_line_bits   (in_line_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_scl        (out_scl),
    .out_sda        (out_sda),
    .out_rx_byte    (out_rx_byte),
    .out_ack_in     (out_ack_in),
    .out_last       (out_last),
    .pending_writes (pending_writes),
    .mismatch_count (mismatch_count)
  );

  // Stall the line-write channel at random; the rate follows the current phase.
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Watchdog: reset on any accepted request or line write, else advance; fail at QUIET_LIMIT.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one request, optionally after some idle cycles, and hold it until taken.
  // Valid only goes low when an idle gap is chosen, so back-to-back requests keep it high.
  task automatic send_request(input logic [2:0] mode, input logic [7:0] tx, input logic ack,
                              input logic [7:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_tx_byte   <= tx;
    in_ack_out   <= ack;
    in_line_bits <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  // Drop valid and hold off until every predicted line write has come out.
  // Wait for the next clock edge first so the count includes the request just taken.
  task automatic drain_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_writes != 0) @(posedge clk);
  endtask

  // Noise: any mode code, including the ignored ones, with random fields.
  task automatic send_noise();
    int count;
    count = $urandom_range(3, 1);
    for (int i = 0; i < count; i++)
      send_request(3'($urandom_range(7)), 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  // One bus transfer: start, address byte, acknowledge, a few data bytes, stop.
  // Now and then leave out the stop so the next start lands as a repeated start.
  task automatic run_transfer();
    int   n_bytes;
    logic reading;
    n_bytes = $urandom_range(4, 1);
    reading = 1'($urandom);
    send_request(MODE_START, 8'($urandom), 1'($urandom), 8'($urandom));
    send_request(MODE_WRITE, 8'($urandom), 1'($urandom), 8'($urandom));
    send_request(MODE_RECV_ACK, 8'($urandom), 1'($urandom), 8'($urandom));
    for (int i = 0; i < n_bytes; i++) begin
      if (reading) begin
        send_request(MODE_READ, 8'($urandom), 1'($urandom), 8'($urandom));
        // master NACKs the final byte, occasionally an earlier one too
        send_request(MODE_SEND_ACK, 8'($urandom),
                     (i == n_bytes - 1) || ($urandom_range(9) == 0), 8'($urandom));
      end else begin
        send_request(MODE_WRITE, 8'($urandom), 1'($urandom), 8'($urandom));
        send_request(MODE_RECV_ACK, 8'($urandom), 1'($urandom), 8'($urandom));
      end
    end
    if ($urandom_range(9) != 0)
      send_request(MODE_STOP, 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic run_random(input int until_count);
    while (requests_sent < until_count) begin
      if ($urandom_range(99) < 15) send_noise();
      else run_transfer();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender mostly busy, receiver mostly stalled.
    send_idle_pct = 26;
    stall_pct     = 87;

    // Directed: byte extremes in both directions, ACK and NACK both ways,
    // the ignored mode codes, and back-to-back stops.
    send_request(MODE_START,    8'h00, 1'b0, 8'hFF);
    send_request(MODE_WRITE,    8'hFF, 1'b0, 8'h00);
    send_request(MODE_RECV_ACK, 8'hFF, 1'b1, 8'h00);
    send_request(MODE_WRITE,    8'h00, 1'b1, 8'hFF);
    send_request(MODE_RECV_ACK, 8'h00, 1'b0, 8'h80);
    send_request(MODE_WRITE,    8'hA5, 1'b0, 8'h5A);
    send_request(MODE_RECV_ACK, 8'h5A, 1'b1, 8'h7F);
    send_request(MODE_READ,     8'hFF, 1'b1, 8'h00);
    send_request(MODE_SEND_ACK, 8'h00, 1'b0, 8'hFF);
    send_request(MODE_READ,     8'h00, 1'b0, 8'hFF);
    send_request(MODE_SEND_ACK, 8'hFF, 1'b1, 8'h00);
    send_request(MODE_READ,     8'h3C, 1'b1, 8'h5A);
    send_request(MODE_RECV_ACK, 8'hC3, 1'b0, 8'hFF);
    send_request(MODE_UNUSED_LO, 8'hFF, 1'b1, 8'hFF);
    send_request(MODE_UNUSED_HI, 8'h00, 1'b0, 8'h00);
    send_request(MODE_STOP,     8'hFF, 1'b1, 8'hFF);
    send_request(MODE_STOP,     8'h00, 1'b0, 8'h00);
    send_request(MODE_START,    8'h5A, 1'b1, 8'hA5);
    send_request(MODE_START,    8'hA5, 1'b0, 8'h5A);
    send_request(MODE_WRITE,    8'h81, 1'b1, 8'h01);
    send_request(MODE_STOP,     8'h7E, 1'b0, 8'hFE);

    run_random(TARGET_REQUESTS / 3);
    drain_requests();

    // Phase two: swap the rates.
    send_idle_pct = 87;
    stall_pct     = 26;
    run_random(2 * TARGET_REQUESTS / 3);
    drain_requests();

    // Phase three: full rate on both sides.
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random(TARGET_REQUESTS);
    drain_requests();

    // Hold a while longer so any extra line write is caught before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_writes == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== i2c_master_line_sequencer.f =====
rtl/i2cmls_pkg.sv
rtl/i2cmls_front.sv
rtl/i2cmls_queue.sv
rtl/i2cmls_back.sv
rtl/i2c_master_line_sequencer.sv
dv/i2cmls_line_checker.sv
dv/tb_i2c_master_line_sequencer.sv
